/* design/column_text_type_sniffer_macros.svh */
// Assertion helpers for the column type sniffer.
`ifndef COLUMN_TEXT_TYPE_SNIFFER_MACROS_SVH
`define COLUMN_TEXT_TYPE_SNIFFER_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define CTTS_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, checked out of reset.
`define CTTS_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* design/ctts_pkg.sv */
package ctts_pkg;

   localparam logic [1:0] OP_BYTE       = 2'd0;
   localparam logic [1:0] OP_EMPTY      = 2'd1;
   localparam logic [1:0] OP_NULL       = 2'd2;
   localparam logic [1:0] OP_NEW_COLUMN = 2'd3;

   localparam logic [2:0] KIND_INTEGER   = 3'd0;
   localparam logic [2:0] KIND_NUMERIC   = 3'd1;
   localparam logic [2:0] KIND_DATE      = 3'd2;
   localparam logic [2:0] KIND_TIME      = 3'd3;
   localparam logic [2:0] KIND_TIMESTAMP = 3'd4;
   localparam logic [2:0] KIND_LONGTEXT  = 3'd5;

   localparam logic [7:0] ROW_LIMIT_RESET = 8'd100;
   localparam logic [7:0] ROWS_MAX        = 8'd255;
   localparam logic [4:0] POS_SAT         = 5'd20;

   localparam logic [4:0] DATE_LEN  = 5'd10;
   localparam logic [4:0] TIME_LEN  = 5'd8;
   localparam logic [4:0] STAMP_LEN = 5'd19;
   localparam logic [4:0] STAMP_GAP = 5'd10;
   localparam logic [4:0] STAMP_TIME_START = 5'd11;

   localparam logic [7:0] CH_ZERO  = 8'h30;
   localparam logic [7:0] CH_NINE  = 8'h39;
   localparam logic [7:0] CH_MINUS = 8'h2D;
   localparam logic [7:0] CH_PLUS  = 8'h2B;
   localparam logic [7:0] CH_DOT   = 8'h2E;
   localparam logic [7:0] CH_COMMA = 8'h2C;
   localparam logic [7:0] CH_COLON = 8'h3A;

   function automatic logic sub_char(input logic [7:0] b, input logic minus_ok);
      return (b >= CH_ZERO && b <= CH_NINE) || b == CH_PLUS || (minus_ok && b == CH_MINUS);
   endfunction

   function automatic logic date_char(input logic [4:0] p, input logic [7:0] b);
      logic ok;
      if (p == 5'd4 || p == 5'd7) ok = (b == CH_MINUS);
      else if (p == 5'd1 || p == 5'd2) ok = sub_char(b, 1'b0);
      else if (p < DATE_LEN) ok = sub_char(b, 1'b1);
      else ok = 1'b0;
      return ok;
   endfunction

   function automatic logic time_char(input logic [4:0] p, input logic [7:0] b);
      logic ok;
      if (p == 5'd2 || p == 5'd5) ok = (b == CH_COLON);
      else if (p < TIME_LEN) ok = sub_char(b, 1'b1);
      else ok = 1'b0;
      return ok;
   endfunction

   function automatic logic stamp_char(input logic [4:0] p, input logic [7:0] b);
      logic ok;
      if (p < DATE_LEN) ok = date_char(p, b);
      else if (p == STAMP_GAP) ok = 1'b1;
      else if (p < STAMP_LEN) ok = time_char(p - STAMP_TIME_START, b);
      else ok = 1'b0;
      return ok;
   endfunction

endpackage

/* design/column_text_type_sniffer.sv */
// Column type sniffer. Takes one item per clock while req_stall is low: a cell byte, an
// empty cell, a null cell or a new-column marker. Each cell end yields one result with
// the current type guess (integer, numeric, date, time, timestamp, long text) and a
// settled flag; after a settled result nothing is reported until the next new-column item.
// Throughput is one item per cycle when the result side does not stall. An accepted item
// is held in the input register, the per-cell state update runs from it, and that
// update loads the result register, which drives the outputs. A stalled result holds the
// input register, which then stalls the input. row_limit is written through
// csr_wr_en/csr_wr_data; the user must write it only while idle (the block does not check).
`include "column_text_type_sniffer_macros.svh"

module column_text_type_sniffer
   import ctts_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [1:0] req_opcode,
   input  logic [7:0] req_byte_value,
   input  logic       req_last_in_cell,
   input  logic       req_last_row,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [2:0] rsp_type_code,
   output logic       rsp_settled,
   input  logic       csr_wr_en,
   input  logic [7:0] csr_wr_data
);

   logic       in_valid_ff, in_valid_in;
   logic [1:0] in_op_ff;
   logic [7:0] in_byte_ff;
   logic       in_last_ff, in_last_row_ff;

   logic [7:0] row_limit_ff;
   logic [2:0] guess_ff, guess_in;
   logic [7:0] rows_ff, rows_in;
   logic [4:0] pos_ff, pos_in;
   logic       int_ok_ff, int_ok_in;
   logic       num_ok_ff, num_ok_in;
   logic       date_ok_ff, date_ok_in;
   logic       time_ok_ff, time_ok_in;
   logic       stamp_ok_ff, stamp_ok_in;
   logic       minus_ff, minus_in;
   logic       done_ff, done_in;

   logic       rsp_valid_ff, rsp_valid_in;
   logic [2:0] rsp_type_ff, rsp_type_in;
   logic       rsp_settled_ff, rsp_settled_in;

   logic out_free, advance, accept, produce, finish, examine;
   logic int_class, num_class;

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign advance   = in_valid_ff && out_free;
   assign req_stall = in_valid_ff && !out_free;
   assign accept    = req_valid && !req_stall;

   assign in_valid_in = accept || (in_valid_ff && !advance);

   assign int_class = sub_char(in_byte_ff, 1'b1);
   assign num_class = int_class || in_byte_ff == CH_DOT || in_byte_ff == CH_COMMA;

   always_comb begin
      guess_in       = guess_ff;
      rows_in        = rows_ff;
      pos_in         = pos_ff;
      int_ok_in      = int_ok_ff;
      num_ok_in      = num_ok_ff;
      date_ok_in     = date_ok_ff;
      time_ok_in     = time_ok_ff;
      stamp_ok_in    = stamp_ok_ff;
      minus_in       = minus_ff;
      done_in        = done_ff;
      produce        = 1'b0;
      finish         = 1'b0;
      examine        = 1'b0;
      rsp_settled_in = 1'b0;
      if (advance) begin
         if (in_op_ff == OP_NEW_COLUMN) begin
            guess_in    = KIND_INTEGER;
            rows_in     = '0;
            done_in     = 1'b0;
            pos_in      = '0;
            int_ok_in   = 1'b1;
            num_ok_in   = 1'b1;
            date_ok_in  = 1'b1;
            time_ok_in  = 1'b1;
            stamp_ok_in = 1'b1;
            minus_in    = 1'b0;
         end else if (!done_ff) begin
            case (in_op_ff)
               OP_BYTE: begin
                  if (minus_ff || !int_class) int_ok_in = 1'b0;
                  if (minus_ff || !num_class) num_ok_in = 1'b0;
                  minus_in = (in_byte_ff == CH_MINUS) && (pos_ff != '0) && !in_last_ff;
                  if (!date_char(pos_ff, in_byte_ff)) date_ok_in = 1'b0;
                  if (!time_char(pos_ff, in_byte_ff)) time_ok_in = 1'b0;
                  if (!stamp_char(pos_ff, in_byte_ff)) stamp_ok_in = 1'b0;
                  if (in_last_ff) begin
                     if (pos_ff != DATE_LEN - 5'd1) date_ok_in = 1'b0;
                     if (pos_ff != TIME_LEN - 5'd1) time_ok_in = 1'b0;
                     if (pos_ff != STAMP_LEN - 5'd1) stamp_ok_in = 1'b0;
                  end
                  if (pos_ff < POS_SAT) pos_in = pos_ff + 5'd1;
                  finish  = in_last_ff;
                  examine = 1'b1;
               end
               OP_EMPTY: begin
                  int_ok_in   = 1'b0;
                  num_ok_in   = 1'b0;
                  date_ok_in  = 1'b0;
                  time_ok_in  = 1'b0;
                  stamp_ok_in = 1'b0;
                  finish      = 1'b1;
                  examine     = 1'b1;
               end
               default: begin
                  finish = 1'b1;
               end
            endcase
            if (finish) begin
               if (row_limit_ff == '0) begin
                  rsp_settled_in = 1'b1;
               end else begin
                  if (examine) begin
                     if (guess_in == KIND_INTEGER && !int_ok_in) guess_in = KIND_NUMERIC;
                     if (guess_in == KIND_NUMERIC && !num_ok_in) guess_in = KIND_DATE;
                     if (guess_in == KIND_DATE && !date_ok_in) guess_in = KIND_TIME;
                     if (guess_in == KIND_TIME && !time_ok_in) guess_in = KIND_TIMESTAMP;
                     if (guess_in == KIND_TIMESTAMP && !stamp_ok_in) guess_in = KIND_LONGTEXT;
                  end
                  if (rows_ff != ROWS_MAX) rows_in = rows_ff + 8'd1;
                  rsp_settled_in = guess_in == KIND_LONGTEXT || rows_in >= row_limit_ff
                                   || in_last_row_ff;
               end
               pos_in      = '0;
               int_ok_in   = 1'b1;
               num_ok_in   = 1'b1;
               date_ok_in  = 1'b1;
               time_ok_in  = 1'b1;
               stamp_ok_in = 1'b1;
               minus_in    = 1'b0;
               done_in     = rsp_settled_in;
               produce     = 1'b1;
            end
         end
      end
   end

   assign rsp_type_in  = produce ? guess_in : rsp_type_ff;
   assign rsp_valid_in = produce || (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         row_limit_ff <= ROW_LIMIT_RESET;
         guess_ff     <= KIND_INTEGER;
         rows_ff      <= '0;
         pos_ff       <= '0;
         int_ok_ff    <= 1'b1;
         num_ok_ff    <= 1'b1;
         date_ok_ff   <= 1'b1;
         time_ok_ff   <= 1'b1;
         stamp_ok_ff  <= 1'b1;
         minus_ff     <= 1'b0;
         done_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
         if (csr_wr_en) row_limit_ff <= csr_wr_data;
         guess_ff     <= guess_in;
         rows_ff      <= rows_in;
         pos_ff       <= pos_in;
         int_ok_ff    <= int_ok_in;
         num_ok_ff    <= num_ok_in;
         date_ok_ff   <= date_ok_in;
         time_ok_ff   <= time_ok_in;
         stamp_ok_ff  <= stamp_ok_in;
         minus_ff     <= minus_in;
         done_ff      <= done_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         in_op_ff       <= req_opcode;
         in_byte_ff     <= req_byte_value;
         in_last_ff     <= req_last_in_cell;
         in_last_row_ff <= req_last_row;
      end
      rsp_type_ff <= rsp_type_in;
      if (produce) rsp_settled_ff <= rsp_settled_in;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_type_code = rsp_type_ff;
   assign rsp_settled   = rsp_settled_ff;

   `CTTS_ASSERT_NOW(a_longtext_settles, clock, reset,
      rsp_valid_ff && rsp_type_ff == KIND_LONGTEXT, rsp_settled_ff,
      "long text result not settled")
   `CTTS_ASSERT_NEXT(a_settle_marks_done, clock, reset,
      produce && rsp_settled_in, done_ff,
      "settled result did not close the column")
   `CTTS_ASSERT_NOW(a_no_result_when_done, clock, reset,
      done_ff, !produce,
      "result produced after column settled")
   `CTTS_ASSERT_NOW(a_guess_range, clock, reset,
      1'b1, guess_ff <= KIND_LONGTEXT && pos_ff <= POS_SAT,
      "guess or position out of range")

endmodule

/* tb/sv/tb_column_text_type_sniffer.sv */
module tb_column_text_type_sniffer
   import ctts_pkg::*;
();
   timeunit 1ns;
   timeprecision 1ps;

   localparam int HOLD_CYCLES    = 300;
   localparam int SETTLE_CYCLES  = 4;
   localparam int DRAIN_CYCLES   = 8;
   localparam int WATCHDOG_LIMIT = 4000;

   typedef struct packed {
      logic [2:0] kind;
      logic       settled;
   } verdict_type;

   class sniff_scoreboard;
      logic [7:0]  row_limit;
      logic [2:0]  guess;
      logic [7:0]  rows_seen;
      logic [4:0]  pos;
      bit          int_ok, num_ok, date_ok, time_ok, stamp_ok;
      bit          minus_pending;
      bit          done;
      verdict_type verdicts_q[$];
      int          errors;

      function new();
         row_limit = ROW_LIMIT_RESET;
         guess = KIND_INTEGER;
         rows_seen = '0;
         done = 1'b0;
         errors = 0;
         clear_cell();
      endfunction

      function void clear_cell();
         pos = '0;
         int_ok = 1'b1;
         num_ok = 1'b1;
         date_ok = 1'b1;
         time_ok = 1'b1;
         stamp_ok = 1'b1;
         minus_pending = 1'b0;
      endfunction

      function bit field_ok(logic [7:0] b, bit minus_ok);
         return (b >= CH_ZERO && b <= CH_NINE) || b == CH_PLUS || (minus_ok && b == CH_MINUS);
      endfunction

      function bit date_at(int p, logic [7:0] b);
         case (p)
            4, 7:                return b == CH_MINUS;
            1, 2:                return field_ok(b, 1'b0);
            0, 3, 5, 6, 8, 9:    return field_ok(b, 1'b1);
            default:             return 1'b0;
         endcase
      endfunction

      function bit time_at(int p, logic [7:0] b);
         case (p)
            2, 5:                return b == CH_COLON;
            0, 1, 3, 4, 6, 7:    return field_ok(b, 1'b1);
            default:             return 1'b0;
         endcase
      endfunction

      function bit stamp_at(int p, logic [7:0] b);
         if (p < int'(DATE_LEN)) return date_at(p, b);
         if (p == int'(STAMP_GAP)) return 1'b1;
         if (p < int'(STAMP_LEN)) return time_at(p - int'(STAMP_TIME_START), b);
         return 1'b0;
      endfunction

      function void take_byte(logic [7:0] b, bit last);
         bit int_class, num_class;
         int_class = field_ok(b, 1'b1);
         num_class = int_class || b == CH_DOT || b == CH_COMMA;
         if (minus_pending) begin
            int_ok = 1'b0;
            num_ok = 1'b0;
         end
         if (!int_class) int_ok = 1'b0;
         if (!num_class) num_ok = 1'b0;
         minus_pending = (b == CH_MINUS) && (pos != 0) && !last;
         if (!date_at(pos, b)) date_ok = 1'b0;
         if (!time_at(pos, b)) time_ok = 1'b0;
         if (!stamp_at(pos, b)) stamp_ok = 1'b0;
         if (last) begin
            if (pos != DATE_LEN - 1) date_ok = 1'b0;
            if (pos != TIME_LEN - 1) time_ok = 1'b0;
            if (pos != STAMP_LEN - 1) stamp_ok = 1'b0;
         end
         if (pos < POS_SAT) pos = pos + 1'b1;
      endfunction

      function void close_cell(bit examine, bit last_row);
         verdict_type v;
         bit fin;
         if (row_limit == 0) begin
            fin = 1'b1;
         end else begin
            if (examine) begin
               if (guess == KIND_INTEGER && !int_ok) guess = KIND_NUMERIC;
               if (guess == KIND_NUMERIC && !num_ok) guess = KIND_DATE;
               if (guess == KIND_DATE && !date_ok) guess = KIND_TIME;
               if (guess == KIND_TIME && !time_ok) guess = KIND_TIMESTAMP;
               if (guess == KIND_TIMESTAMP && !stamp_ok) guess = KIND_LONGTEXT;
            end
            if (rows_seen != ROWS_MAX) rows_seen = rows_seen + 1'b1;
            fin = guess == KIND_LONGTEXT || rows_seen >= row_limit || last_row;
         end
         clear_cell();
         done = fin;
         v.kind = guess;
         v.settled = fin;
         verdicts_q.push_back(v);
      endfunction

      // returns 0 when the item is ignored (column already settled)
      function bit note_item(logic [1:0] op, logic [7:0] b, bit last, bit last_row);
         if (op == OP_NEW_COLUMN) begin
            guess = KIND_INTEGER;
            rows_seen = '0;
            done = 1'b0;
            clear_cell();
            return 1'b1;
         end
         if (done) return 1'b0;
         case (op)
            OP_BYTE: begin
               take_byte(b, last);
               if (last) close_cell(1'b1, last_row);
            end
            OP_EMPTY: begin
               int_ok = 1'b0;
               num_ok = 1'b0;
               date_ok = 1'b0;
               time_ok = 1'b0;
               stamp_ok = 1'b0;
               close_cell(1'b1, last_row);
            end
            default: close_cell(1'b0, last_row);
         endcase
         return 1'b1;
      endfunction

      task report(string what);
         $display("MISMATCH at %0t: %s", $realtime, what);
         errors++;
      endtask

      task check_result(logic [2:0] kind, logic settled);
         verdict_type want;
         if (verdicts_q.size() == 0) begin
            report($sformatf("result kind %0d settled %0b with none pending", kind, settled));
            return;
         end
         want = verdicts_q.pop_front();
         if (kind !== want.kind)
            report($sformatf("type_code %0d, want %0d", kind, want.kind));
         if (settled !== want.settled)
            report($sformatf("settled %0b, want %0b", settled, want.settled));
      endtask

      function int pending();
         return verdicts_q.size();
      endfunction
   endclass

   logic       clock;
   logic       reset;
   logic       req_valid;
   logic       req_stall;
   logic [1:0] req_opcode;
   logic [7:0] req_byte_value;
   logic       req_last_in_cell;
   logic       req_last_row;
   logic       rsp_valid;
   logic       rsp_stall;
   logic [2:0] rsp_type_code;
   logic       rsp_settled;
   logic       csr_wr_en;
   logic [7:0] csr_wr_data;

   sniff_scoreboard sb = new();
   logic [7:0] cell_text[$];
   int  live_items = 0;
   int  hold_asked = 0;
   int  hold_served = 0;
   int  idle_cycles = 0;
   bit  quiet = 1'b0;

   column_text_type_sniffer i_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_opcode       (req_opcode),
      .req_byte_value   (req_byte_value),
      .req_last_in_cell (req_last_in_cell),
      .req_last_row     (req_last_row),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_type_code    (rsp_type_code),
      .rsp_settled      (rsp_settled),
      .csr_wr_en        (csr_wr_en),
      .csr_wr_data      (csr_wr_data)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   function automatic logic [7:0] rnd_byte();
      return 8'($urandom_range(255));
   endfunction

   function automatic logic rnd_bit();
      return 1'($urandom_range(1));
   endfunction

   // digit most of the time, sometimes a sign
   function automatic logic [7:0] field_glyph(bit minus_ok);
      int r;
      r = $urandom_range(9);
      if (r < 8) return CH_ZERO + 8'($urandom_range(9));
      if (r == 9 && minus_ok) return CH_MINUS;
      return CH_PLUS;
   endfunction

   function automatic logic [7:0] date_glyph(int p);
      if (p == 4 || p == 7) return CH_MINUS;
      return field_glyph(p != 1 && p != 2);
   endfunction

   function automatic logic [7:0] time_glyph(int p);
      if (p == 2 || p == 5) return CH_COLON;
      return field_glyph(1'b1);
   endfunction

   function automatic void build_cell(logic [2:0] kind);
      int i, n;
      cell_text.delete();
      case (kind)
         KIND_INTEGER, KIND_NUMERIC: begin
            n = $urandom_range(1, 6);
            for (i = 0; i < n; i++) cell_text.push_back(field_glyph(1'b0));
            if ($urandom_range(2) == 0) cell_text[0] = rnd_bit() ? CH_PLUS : CH_MINUS;
            if ($urandom_range(5) == 0) cell_text.push_back(CH_MINUS);
            if (kind == KIND_NUMERIC)
               cell_text.insert($urandom_range(cell_text.size()), rnd_bit() ? CH_DOT : CH_COMMA);
         end
         KIND_DATE: for (i = 0; i < DATE_LEN; i++) cell_text.push_back(date_glyph(i));
         KIND_TIME: for (i = 0; i < TIME_LEN; i++) cell_text.push_back(time_glyph(i));
         KIND_TIMESTAMP: begin
            for (i = 0; i < DATE_LEN; i++) cell_text.push_back(date_glyph(i));
            cell_text.push_back(rnd_byte());
            for (i = 0; i < TIME_LEN; i++) cell_text.push_back(time_glyph(i));
         end
         default: begin
            n = $urandom_range(1, 24);
            for (i = 0; i < n; i++) cell_text.push_back(rnd_byte());
         end
      endcase
   endfunction

   function automatic void mangle_cell();
      int r;
      r = $urandom_range(19);
      if (r < 2) cell_text[$urandom_range(cell_text.size() - 1)] = rnd_byte();
      else if (r == 2) cell_text.push_back(field_glyph(1'b1));
      else if (r == 3 && cell_text.size() > 1) void'(cell_text.pop_back());
   endfunction

   task automatic send_item(input logic [1:0] op, input logic [7:0] b, input logic last,
                            input logic lr);
      if (!quiet && $urandom_range(99) < 15) begin
         @(negedge clock);
         req_valid = 1'b0;
         repeat ($urandom_range(2)) @(negedge clock);
      end
      @(negedge clock);
      req_valid = 1'b1;
      req_opcode = op;
      req_byte_value = b;
      req_last_in_cell = last;
      req_last_row = lr;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      void'(sb.note_item(op, b, last, lr));
      live_items++;
   endtask

   task automatic send_cell(input logic lr);
      int i;
      if (cell_text.size() == 0) begin
         send_item(OP_EMPTY, rnd_byte(), rnd_bit(), lr);
      end else begin
         for (i = 0; i < cell_text.size(); i++) begin
            if (i == cell_text.size() - 1) send_item(OP_BYTE, cell_text[i], 1'b1, lr);
            else send_item(OP_BYTE, cell_text[i], 1'b0, rnd_bit());
         end
      end
   endtask

   task automatic send_text(input string s, input logic lr);
      int i;
      cell_text.delete();
      for (i = 0; i < s.len(); i++) cell_text.push_back(s[i]);
      send_cell(lr);
   endtask

   task automatic send_column(input logic [2:0] style, input int rows, input bit marked);
      int r, k, n, pick;
      logic lr;
      send_item(OP_NEW_COLUMN, rnd_byte(), rnd_bit(), rnd_bit());
      for (r = 0; r < rows; r++) begin
         lr = marked && (r == rows - 1);
         pick = $urandom_range(99);
         if (pick < 8) begin
            send_item(OP_NULL, rnd_byte(), rnd_bit(), lr);
         end else if (pick < 13) begin
            send_item(OP_EMPTY, rnd_byte(), rnd_bit(), lr);
         end else if (pick < 18) begin
            // cell cut short by an empty or null cell
            build_cell(3'($urandom_range(5)));
            n = $urandom_range(1, cell_text.size());
            for (k = 0; k < n; k++) send_item(OP_BYTE, cell_text[k], 1'b0, rnd_bit());
            send_item(rnd_bit() ? OP_NULL : OP_EMPTY, rnd_byte(), rnd_bit(), lr);
         end else if (pick < 82) begin
            build_cell(style);
            mangle_cell();
            send_cell(lr);
         end else begin
            build_cell(3'($urandom_range(5)));
            send_cell(lr);
         end
      end
   endtask

   task automatic send_long_column();
      int r;
      send_item(OP_NEW_COLUMN, rnd_byte(), rnd_bit(), rnd_bit());
      for (r = 0; r < int'(ROWS_MAX) + 5; r++) begin
         if ($urandom_range(9) == 0) begin
            build_cell(KIND_INTEGER);
            send_cell(1'b0);
         end else begin
            send_item(OP_NULL, rnd_byte(), rnd_bit(), 1'b0);
         end
      end
   endtask

   task automatic pause_until_drained();
      @(negedge clock);
      req_valid = 1'b0;
      while (sb.pending() != 0) @(posedge clock);
   endtask

   task automatic load_row_limit(input logic [7:0] value);
      pause_until_drained();
      repeat (SETTLE_CYCLES) @(negedge clock);
      csr_wr_en = 1'b1;
      csr_wr_data = value;
      @(negedge clock);
      csr_wr_en = 1'b0;
      sb.row_limit = value;
   endtask

   task automatic run_phase(input int count, input bit with_pressure);
      int start;
      bit held, paused;
      start = live_items;
      held = 1'b0;
      paused = 1'b0;
      while (live_items - start < count) begin
         if (with_pressure && !held && live_items - start >= count / 3) begin
            hold_asked++;
            held = 1'b1;
         end
         if (with_pressure && !paused && live_items - start >= 2 * count / 3) begin
            pause_until_drained();
            paused = 1'b1;
         end
         send_column(3'($urandom_range(5)),
                     ($urandom_range(9) == 0) ? $urandom_range(12, 30) : $urandom_range(1, 6),
                     $urandom_range(9) < 7);
      end
   endtask

   task automatic run_directed();
      send_item(OP_NEW_COLUMN, 8'h00, 1'b0, 1'b0);
      send_text("7", 1'b0);
      send_text("+0-", 1'b0);
      send_text("9,-", 1'b0);
      send_item(OP_BYTE, 8'h00, 1'b0, 1'b1);
      send_item(OP_NULL, 8'hFF, 1'b1, 1'b0);
      send_text("1-2", 1'b0);
      send_item(OP_BYTE, CH_ZERO, 1'b1, 1'b0);
      send_item(OP_NEW_COLUMN, 8'hFF, 1'b1, 1'b1);
      send_text("5", 1'b1);
      send_item(OP_NEW_COLUMN, 8'h00, 1'b0, 1'b0);
      send_item(OP_EMPTY, 8'h00, 1'b0, 1'b0);
      send_item(OP_NEW_COLUMN, 8'h00, 1'b0, 1'b0);
      send_item(OP_BYTE, 8'hFF, 1'b0, 1'b0);
      send_item(OP_EMPTY, 8'h00, 1'b1, 1'b1);
   endtask

   // result side
   initial begin
      rsp_stall = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_asked != hold_served) begin
            hold_served = hold_asked;
            rsp_stall = 1'b1;
            repeat (HOLD_CYCLES) @(negedge clock);
            rsp_stall = 1'b0;
         end else begin
            rsp_stall = !quiet && ($urandom_range(99) < 23);
         end
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) sb.check_result(rsp_type_code, rsp_settled);
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("timeout: no item moved for %0d cycles", WATCHDOG_LIMIT);
         $display("CHECK FAILED");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      reset = 1'b1;
      req_valid = 1'b0;
      req_opcode = OP_BYTE;
      req_byte_value = '0;
      req_last_in_cell = 1'b0;
      req_last_row = 1'b0;
      csr_wr_en = 1'b0;
      csr_wr_data = '0;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      run_directed();
      run_phase(220, 1'b1);
      load_row_limit(8'd1);
      run_phase(100, 1'b0);
      load_row_limit(ROWS_MAX);
      send_long_column();
      run_phase(120, 1'b0);
      load_row_limit(8'd0);
      run_phase(80, 1'b0);
      load_row_limit(8'd3);
      quiet = 1'b1;
      run_phase(160, 1'b0);
      quiet = 1'b0;
      load_row_limit(8'($urandom_range(2, 30)));
      run_phase(140, 1'b0);

      pause_until_drained();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (sb.errors == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule
